### src/imufcy_pkg.sv
// shared types and constants for the imu frame checksum and yaw filter
package imufcy_pkg;

    // frame status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_START = 2'd1;
    localparam logic [1:0] STATUS_BAD_SUM   = 2'd2;

    // frame constants
    localparam logic [7:0]  SYNC_BYTE   = 8'h55;
    localparam int unsigned YAW_HI_POS  = 6;
    localparam int unsigned YAW_LO_POS  = 7;

    // filter weight, unsigned q1.15
    localparam logic [15:0] ALPHA_RESET = 16'd31130;
    localparam logic [16:0] ALPHA_ONE   = 17'd32768;

    // one finished frame handed from the front end to the filter
    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] yaw;
    } t_frame_rec;

    // filter sequencer states
    typedef enum logic [1:0] {
        FLT_IDLE,
        FLT_MUL,
        FLT_ADD
    } t_flt_state;

endpackage

### src/imu_frame_checksum_yaw_filter.sv
// top level: frame parser, record queue and yaw filter
//
// Sensor bytes enter on the rx channel (i_rx_valid / o_rx_ready), one request
// per cycle at most. Frames are FRAME_LEN bytes long, counted from reset. At
// the last byte of a frame the parser checks the start bytes and the 16-bit
// sum and pushes a frame record into a two-entry queue.
// The filter takes one record at a time: pop, multiply, add. One result
// request per frame appears on o_res_valid once the record has passed the
// queue, the record register, the product registers and the result register,
// with frame status, raw yaw (zero on a bad frame) and filtered yaw.
// Bytes are taken every cycle; only the closing byte of a frame waits, and
// only when the queue holds two records while the result receiver stalls.
// A waiting result stays stable until i_res_ready takes it.
// The user must write the weight via i_cfg_wr_en / i_cfg_wr_data only while
// no frame is in flight (not enforced); values above 32768 act as 32768.
// Synchronous reset clears the byte position, sum, filter state and queue,
// and loads the weight with 31130 (0.95).
module imu_frame_checksum_yaw_filter #(
    parameter int FRAME_LEN = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [1:0]         o_frame_status,
    output logic signed [15:0] o_yaw_raw,
    output logic signed [15:0] o_yaw_filtered,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data
);
    import imufcy_pkg::*;

    logic [15:0] r_alpha;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    t_frame_rec  q_in_rec;
    t_frame_rec  q_out_rec;

    // weight register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg_wr_en) begin
            r_alpha <= i_cfg_wr_data;
        end
    end

    // front end
    imufcy_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_ready (o_rx_ready),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_rec    (q_in_rec)
    );

    // record queue
    imufcy_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_out_rec)
    );

    // filter back end
    imufcy_filter u_filter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_alpha_q15    (r_alpha),
        .i_q_valid      (q_valid),
        .i_q_rec        (q_out_rec),
        .o_q_pop        (q_pop),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_frame_status (o_frame_status),
        .o_yaw_raw      (o_yaw_raw),
        .o_yaw_filtered (o_yaw_filtered)
    );

endmodule

### src/imufcy_front.sv
// frame parser: byte position, checksum, start check and yaw capture
module imufcy_front #(
    parameter int FRAME_LEN = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rx_valid,
    input  logic [7:0]             i_rx_byte,
    output logic                   o_rx_ready,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output imufcy_pkg::t_frame_rec o_q_rec
);
    import imufcy_pkg::*;

    localparam int POS_W = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_CHKHI = POS_W'(FRAME_LEN - 2);
    localparam logic [POS_W-1:0] POS_YAWHI = POS_W'(YAW_HI_POS);
    localparam logic [POS_W-1:0] POS_YAWLO = POS_W'(YAW_LO_POS);

    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_sum;
    logic             r_start_ok;
    logic [15:0]      r_yaw;
    logic [7:0]       r_chk_hi;

    logic             acc_byte;
    logic             is_last;
    logic [15:0]      received;

    // only the closing byte needs room in the queue
    assign is_last    = (r_pos == POS_LAST);
    assign o_rx_ready = !is_last || !i_q_full;
    assign acc_byte   = i_rx_valid && o_rx_ready;
    assign received   = {r_chk_hi, i_rx_byte};

    // frame record built at the closing byte
    always_comb begin
        o_q_push = acc_byte && is_last;
        o_q_rec.yaw = '0;
        if (!r_start_ok) begin
            o_q_rec.status = STATUS_BAD_START;
        end else if (r_sum != received) begin
            o_q_rec.status = STATUS_BAD_SUM;
        end else begin
            o_q_rec.status = STATUS_OK;
            o_q_rec.yaw    = r_yaw;
        end
    end

    // position, sum and start flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_start_ok <= 1'b1;
        end else if (acc_byte) begin
            if (is_last) begin
                r_pos      <= '0;
                r_sum      <= '0;
                r_start_ok <= 1'b1;
            end else begin
                r_pos <= r_pos + 1'b1;
                if (r_pos != POS_CHKHI) begin
                    r_sum <= r_sum + {8'd0, i_rx_byte};
                end
                if ((r_pos == '0 || r_pos == POS_W'(1)) && i_rx_byte != SYNC_BYTE) begin
                    r_start_ok <= 1'b0;
                end
            end
        end
    end

    // yaw and checksum high byte capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw    <= '0;
            r_chk_hi <= '0;
        end else if (acc_byte) begin
            if (r_pos == POS_YAWHI) begin
                r_yaw[15:8] <= i_rx_byte;
            end
            if (r_pos == POS_YAWLO) begin
                r_yaw[7:0] <= i_rx_byte;
            end
            if (r_pos == POS_CHKHI) begin
                r_chk_hi <= i_rx_byte;
            end
        end
    end

endmodule

### src/imufcy_fifo.sv
// two-entry queue of frame records between parser and filter
module imufcy_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  imufcy_pkg::t_frame_rec i_rec,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_valid,
    output imufcy_pkg::t_frame_rec o_rec
);
    import imufcy_pkg::*;

    t_frame_rec  r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_rec   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/imufcy_filter.sv
// exponential yaw filter and result register
module imufcy_filter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [15:0]            i_alpha_q15,
    input  logic                   i_q_valid,
    input  imufcy_pkg::t_frame_rec i_q_rec,
    output logic                   o_q_pop,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output logic [1:0]             o_frame_status,
    output logic signed [15:0]     o_yaw_raw,
    output logic signed [15:0]     o_yaw_filtered
);
    import imufcy_pkg::*;

    t_flt_state         r_state;
    t_flt_state         n_state;
    t_frame_rec         r_rec;
    logic signed [31:0] r_acc;
    logic signed [33:0] r_prod_new;
    logic signed [49:0] r_prod_old;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic signed [15:0] r_yaw_raw;
    logic signed [15:0] r_yaw_filt;

    logic               ld_prod;
    logic               ld_out;
    logic [16:0]        alpha_sat;
    logic [16:0]        alpha_rest;
    logic signed [51:0] mix;
    logic signed [31:0] acc_next;

    // weight saturated at one
    assign alpha_sat  = ({1'b0, i_alpha_q15} > ALPHA_ONE) ? ALPHA_ONE : {1'b0, i_alpha_q15};
    assign alpha_rest = ALPHA_ONE - alpha_sat;

    // mix of both products, floored by the arithmetic shift
    assign mix      = {{2{r_prod_new[33]}}, r_prod_new, 16'd0}
                    + {{2{r_prod_old[49]}}, r_prod_old};
    assign acc_next = mix[46:15];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FLT_IDLE: begin
                if (i_q_valid) begin
                    n_state = FLT_MUL;
                end
            end
            FLT_MUL: n_state = FLT_ADD;
            FLT_ADD: begin
                if (ld_out) begin
                    n_state = FLT_IDLE;
                end
            end
            default: n_state = FLT_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_q_pop = 1'b0;
        ld_prod = 1'b0;
        ld_out  = 1'b0;
        case (r_state)
            FLT_IDLE: o_q_pop = i_q_valid;
            FLT_MUL:  ld_prod = 1'b1;
            FLT_ADD:  ld_out  = !r_out_valid || i_res_ready;
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FLT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // record and product registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_rec;
        end
        if (ld_prod) begin
            r_prod_new <= 34'($signed({1'b0, alpha_sat})) * 34'(r_rec.yaw);
            r_prod_old <= 50'($signed({1'b0, alpha_rest})) * 50'(r_acc);
        end
    end

    // filter state, updated on good frames only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (ld_out && r_rec.status == STATUS_OK) begin
            r_acc <= acc_next;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_status   <= r_rec.status;
            r_yaw_raw  <= r_rec.yaw;
            r_yaw_filt <= (r_rec.status == STATUS_OK) ? acc_next[31:16] : r_acc[31:16];
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_frame_status = r_status;
    assign o_yaw_raw      = r_yaw_raw;
    assign o_yaw_filtered = r_yaw_filt;

endmodule

### tb/sv/tb_imu_frame_checksum_yaw_filter.sv
// testbench for the imu frame checksum and yaw filter
module tb_imu_frame_checksum_yaw_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import imufcy_pkg::*;

    localparam int FRAME_LEN        = 16;
    localparam int SETTLE_CYCLES    = 12;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PHASES    = 6;
    localparam int FRAMES_PER_PHASE = 16;
    localparam int IDLE_PERCENT     = 12;
    localparam int NO_CFG           = -1;
    localparam int FILL_RANDOM      = -1;

    // one frame result as the block reports it
    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] yaw_raw;
        logic signed [15:0] yaw_filt;
    } t_frame_result;

    // one directed frame: weight to load first, how to corrupt it, payload
    typedef struct packed {
        int            cfg;
        logic [1:0]    sync_bad;
        bit            sum_bad;
        logic [15:0]   yaw;
        int            fill;
        bit            typed;
        t_frame_result res;
    } t_frame_row;

    localparam int DIRECTED_ROWS = 15;

    // directed frames, typed results only where obvious
    t_frame_row frame_table [DIRECTED_ROWS] = '{
        '{NO_CFG,  2'b01, 1'b0, 16'h0100, 'h00, 1'b1,
          '{STATUS_BAD_START, 16'sh0000, 16'sh0000}},
        '{NO_CFG,  2'b00, 1'b1, 16'h0005, 'hFF, 1'b1,
          '{STATUS_BAD_SUM,   16'sh0000, 16'sh0000}},
        '{NO_CFG,  2'b10, 1'b1, 16'h1111, 'hFF, 1'b1,
          '{STATUS_BAD_START, 16'sh0000, 16'sh0000}},
        '{NO_CFG,  2'b11, 1'b0, 16'h2222, FILL_RANDOM, 1'b1,
          '{STATUS_BAD_START, 16'sh0000, 16'sh0000}},
        '{NO_CFG,  2'b00, 1'b0, 16'h7FFF, 'h00, 1'b0, '0},
        '{NO_CFG,  2'b00, 1'b0, 16'h8000, 'hFF, 1'b0, '0},
        '{32768,   2'b00, 1'b0, 16'h8000, 'h00, 1'b1,
          '{STATUS_OK, 16'sh8000, 16'sh8000}},
        '{NO_CFG,  2'b00, 1'b0, 16'h7FFF, 'hFF, 1'b1,
          '{STATUS_OK, 16'sh7FFF, 16'sh7FFF}},
        '{NO_CFG,  2'b00, 1'b1, 16'h0042, FILL_RANDOM, 1'b1,
          '{STATUS_BAD_SUM, 16'sh0000, 16'sh7FFF}},
        '{0,       2'b00, 1'b0, 16'h1234, FILL_RANDOM, 1'b1,
          '{STATUS_OK, 16'sh1234, 16'sh7FFF}},
        '{65535,   2'b00, 1'b0, 16'hFFFF, 'h00, 1'b1,
          '{STATUS_OK, 16'shFFFF, 16'shFFFF}},
        '{1,       2'b00, 1'b0, 16'h7FFF, FILL_RANDOM, 1'b0, '0},
        '{16384,   2'b00, 1'b0, 16'h0000, FILL_RANDOM, 1'b0, '0},
        '{32769,   2'b00, 1'b0, 16'h0064, 'hFF, 1'b1,
          '{STATUS_OK, 16'sh0064, 16'sh0064}},
        '{31130,   2'b00, 1'b0, 16'hFFFB, FILL_RANDOM, 1'b0, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_rx_valid;
    logic               o_rx_ready;
    logic [7:0]         i_rx_byte;
    logic               o_res_valid;
    logic               i_res_ready;
    logic [1:0]         o_frame_status;
    logic signed [15:0] o_yaw_raw;
    logic signed [15:0] o_yaw_filtered;
    logic               i_cfg_wr_en;
    logic [15:0]        i_cfg_wr_data;

    // frame tracker and filter copy
    int unsigned   trk_pos;
    logic [15:0]   trk_sum;
    bit            trk_start_ok;
    logic [15:0]   trk_yaw;
    logic [7:0]    trk_chk_hi;
    int            flt_acc;
    logic [15:0]   flt_alpha;
    t_frame_result frame_expect_q [$];

    // run control and bookkeeping
    bit            calm;
    bit            hold_req;
    int            hold_left;
    int            fail_count;
    int            bytes_sent;
    int            frames_checked;
    int            alpha_writes;
    int            status_seen [3];

    imu_frame_checksum_yaw_filter #(
        .FRAME_LEN (FRAME_LEN)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_frame_status (o_frame_status),
        .o_yaw_raw      (o_yaw_raw),
        .o_yaw_filtered (o_yaw_filtered),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb_imu_frame_checksum_yaw_filter: errors");
        $finish;
    end

    // advance the frame tracker by one accepted byte, queue a result at frame end
    task automatic track_byte(input logic [7:0] b);
        t_frame_result rec;
        longint        a_w;
        longint        mix;
        if (trk_pos < 2 && b != SYNC_BYTE) trk_start_ok = 1'b0;
        if (trk_pos == YAW_HI_POS) trk_yaw[15:8] = b;
        if (trk_pos == YAW_LO_POS) trk_yaw[7:0] = b;
        if (trk_pos < FRAME_LEN - 2) begin
            trk_sum = trk_sum + 16'(b);
            trk_pos++;
        end else if (trk_pos == FRAME_LEN - 2) begin
            trk_chk_hi = b;
            trk_pos++;
        end else begin
            rec.yaw_raw = '0;
            if (!trk_start_ok) begin
                rec.status = STATUS_BAD_START;
            end else if (trk_sum != {trk_chk_hi, b}) begin
                rec.status = STATUS_BAD_SUM;
            end else begin
                // exact convex mix in q16.16, floored by the arithmetic shift
                rec.status  = STATUS_OK;
                rec.yaw_raw = trk_yaw;
                a_w = (flt_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(flt_alpha);
                mix = a_w * (longint'(signed'(trk_yaw)) * 65536)
                    + (longint'(ALPHA_ONE) - a_w) * longint'(flt_acc);
                flt_acc = int'(mix >>> 15);
            end
            rec.yaw_filt = 16'(flt_acc >>> 16);
            frame_expect_q.push_back(rec);
            trk_pos      = 0;
            trk_sum      = '0;
            trk_start_ok = 1'b1;
        end
    endtask

    // offer one byte request, with random gaps, until the block takes it
    task automatic push_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        track_byte(b);
        bytes_sent++;
    endtask

    // build one frame with a correct or corrupted header and checksum
    task automatic send_frame(input logic [1:0] sync_bad, input bit sum_bad,
                              input logic [15:0] yaw, input int fill);
        logic [7:0]  fb [FRAME_LEN];
        logic [15:0] sum;
        sum = '0;
        for (int i = 0; i < FRAME_LEN - 2; i++) begin
            fb[i] = (fill == FILL_RANDOM) ? 8'($urandom_range(255)) : 8'(fill);
        end
        for (int i = 0; i < 2; i++) begin
            fb[i] = sync_bad[i] ? (SYNC_BYTE ^ 8'($urandom_range(255, 1))) : SYNC_BYTE;
        end
        fb[YAW_HI_POS] = yaw[15:8];
        fb[YAW_LO_POS] = yaw[7:0];
        for (int i = 0; i < FRAME_LEN - 2; i++) sum = sum + 16'(fb[i]);
        if (sum_bad) sum = sum ^ 16'($urandom_range(65535, 1));
        fb[FRAME_LEN - 2] = sum[15:8];
        fb[FRAME_LEN - 1] = sum[7:0];
        foreach (fb[i]) push_byte(fb[i]);
    endtask

    // drop the byte request and wait for every pending result
    task automatic drain();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (frame_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // load the filter weight while the block is idle
    task automatic write_alpha(input logic [15:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        flt_alpha = v;
        alpha_writes++;
    endtask

    // result receiver: random stalls plus one long hold-off on request
    initial begin
        i_res_ready = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // compare one taken result with the oldest pending frame
    task automatic check_result();
        t_frame_result exp_r;
        if (frame_expect_q.size() == 0) begin
            $error("result with no frame pending: status %0d", o_frame_status);
            fail_count++;
        end else begin
            exp_r = frame_expect_q.pop_front();
            frames_checked++;
            if (exp_r.status <= STATUS_BAD_SUM) status_seen[exp_r.status]++;
            if (o_frame_status !== exp_r.status) begin
                $error("frame_status: expected %0d, got %0d", exp_r.status, o_frame_status);
                fail_count++;
            end
            if (o_yaw_raw !== exp_r.yaw_raw) begin
                $error("yaw_raw: expected %0d, got %0d", exp_r.yaw_raw, o_yaw_raw);
                fail_count++;
            end
            if (o_yaw_filtered !== exp_r.yaw_filt) begin
                $error("yaw_filtered: expected %0d, got %0d", exp_r.yaw_filt, o_yaw_filtered);
                fail_count++;
            end
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) check_result();
    end

    // stimulus
    initial begin
        int          roll;
        logic [15:0] alpha_v;
        logic [15:0] yaw_v;
        i_rst_n       = 1'b0;
        i_rx_valid    = 1'b0;
        i_rx_byte     = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        fail_count    = 0;
        bytes_sent    = 0;
        frames_checked = 0;
        alpha_writes  = 0;
        status_seen   = '{0, 0, 0};
        trk_pos       = 0;
        trk_sum       = '0;
        trk_start_ok  = 1'b1;
        trk_yaw       = '0;
        trk_chk_hi    = '0;
        flt_acc       = 0;
        flt_alpha     = ALPHA_RESET;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        foreach (frame_table[r]) begin
            if (frame_table[r].cfg != NO_CFG) write_alpha(16'(frame_table[r].cfg));
            send_frame(frame_table[r].sync_bad, frame_table[r].sum_bad,
                       frame_table[r].yaw, frame_table[r].fill);
            if (frame_table[r].typed) begin
                frame_expect_q[frame_expect_q.size() - 1] = frame_table[r].res;
            end
        end

        // random phases, one weight setting each
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       alpha_v = 16'(ALPHA_ONE);
                1:       alpha_v = '0;
                2:       alpha_v = 16'($urandom_range(32768));
                3:       alpha_v = 16'($urandom_range(65535, 32769));
                4:       alpha_v = 16'($urandom_range(32767, 1));
                default: alpha_v = ALPHA_RESET;
            endcase
            write_alpha(alpha_v);
            // one phase with no gaps at all, one with a long receiver hold-off
            calm = (ph == 2);
            if (ph == 4) hold_req = 1'b1;
            for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
                roll = $urandom_range(99);
                if ($urandom_range(9) == 0) begin
                    yaw_v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                end else begin
                    yaw_v = 16'($urandom_range(65535));
                end
                if (roll < 70) begin
                    send_frame(2'b00, 1'b0, yaw_v, FILL_RANDOM);
                end else if (roll < 80) begin
                    send_frame(2'($urandom_range(3, 1)), 1'($urandom_range(1)),
                               yaw_v, FILL_RANDOM);
                end else if (roll < 90) begin
                    send_frame(2'b00, 1'b1, yaw_v, FILL_RANDOM);
                end else begin
                    repeat (FRAME_LEN) push_byte(8'($urandom_range(255)));
                end
            end
        end
        calm = 1'b0;

        drain();
        $display("covered %0d bytes, %0d frames over %0d weight settings",
                 bytes_sent, frames_checked, alpha_writes);
        $display("frame mix: %0d valid, %0d bad start, %0d bad checksum",
                 status_seen[STATUS_OK], status_seen[STATUS_BAD_START],
                 status_seen[STATUS_BAD_SUM]);
        if (fail_count == 0) begin
            $display("tb_imu_frame_checksum_yaw_filter: clean");
        end else begin
            $display("tb_imu_frame_checksum_yaw_filter: errors");
        end
        $finish;
    end

endmodule

### sim.f
src/imufcy_pkg.sv
src/imufcy_front.sv
src/imufcy_fifo.sv
src/imufcy_filter.sv
src/imu_frame_checksum_yaw_filter.sv
tb/sv/tb_imu_frame_checksum_yaw_filter.sv
